// ===== hdl/ax25fcs_pkg.sv =====
// shared types, request codes and crc-16/x.25 byte fold for the ax.25 frame assembler
// no dependencies
`default_nettype none

package ax25fcs_pkg;

  localparam logic [1:0] REQ_ADDR = 2'd0;
  localparam logic [1:0] REQ_HDR  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hffff;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified item: up to three frame bytes plus check byte request
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            fcs_end;
    logic            err;
  } job_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0]  t;
    logic [15:0] w;
    t = b ^ acc[7:0];
    t = t ^ {t[3:0], 4'h0};
    w = {8'h00, acc[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ax25_iframe_assembler_fcs.sv =====
// ax.25 i-frame byte assembler with crc-16/x.25 frame check sequence
// throughput: one output beat per cycle while out_stall is low and jobs are queued; an
// address/data item gives 1 byte, a header 2 (mod 8) or 3 (mod 128), plus 2 check
// bytes when the item ends a frame; these are emitted by the byte sequencer
// four-entry job queue decouples input from output; reset clears queue, mode to modulo 8
// and crc to 0xffff; depends on ax25fcs_pkg, ax25fcs_front, ax25fcs_queue, ax25fcs_back
`default_nettype none

module ax25_iframe_assembler_fcs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_extended_mode,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  byte_value,
  input  wire logic [6:0]  recv_seq,
  input  wire logic [6:0]  send_seq,
  input  wire logic [7:0]  protocol_id,
  input  wire logic        frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             frame_done,
  output logic             seq_error
);
  import ax25fcs_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_avail;
  job_t    push_job;
  job_t    head_job;

  ax25fcs_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_extended_mode (cfg_extended_mode),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .req_type          (req_type),
    .byte_value        (byte_value),
    .recv_seq          (recv_seq),
    .send_seq          (send_seq),
    .protocol_id       (protocol_id),
    .frame_end         (frame_end),
    .q_full            (q_full),
    .q_push            (q_push),
    .job               (push_job)
  );

  ax25fcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_job (head_job)
  );

  ax25fcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_avail     (q_avail),
    .head_job    (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .frame_done  (frame_done),
    .seq_error   (seq_error)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("job queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_avail)
    else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== hdl/ax25fcs_front.sv =====
// front end: input handshake, mode register, item classification into jobs
// depends on ax25fcs_pkg
`default_nettype none

module ax25fcs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_extended_mode,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        req_type,
  input  wire logic [7:0]        byte_value,
  input  wire logic [6:0]        recv_seq,
  input  wire logic [6:0]        send_seq,
  input  wire logic [7:0]        protocol_id,
  input  wire logic              frame_end,
  input  wire logic              q_full,
  output logic                   q_push,
  output ax25fcs_pkg::job_t      job
);
  import ax25fcs_pkg::*;

  logic extended_mode;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      extended_mode <= cfg_extended_mode;
    end
  end

  always_comb begin
    job         = '0;
    job.fcs_end = frame_end;
    q_push      = 1'b0;
    case (req_type)
      REQ_HDR: begin
        q_push = accept;
        if (extended_mode) begin
          job.bytes[0] = {recv_seq, 1'b1};
          job.bytes[1] = {send_seq, 1'b0};
          job.bytes[2] = protocol_id;
          job.nbytes   = 2'd3;
        end else begin
          job.bytes[0] = {recv_seq[2:0], 1'b1, send_seq[2:0], 1'b0};
          job.bytes[1] = protocol_id;
          job.nbytes   = 2'd2;
          job.err      = (recv_seq[6:3] != 4'd0) || (send_seq[6:3] != 4'd0);
        end
      end
      REQ_ADDR, REQ_DATA: begin
        q_push       = accept;
        job.bytes[0] = byte_value;
        job.nbytes   = 2'd1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ax25fcs_queue.sv =====
// short job queue between front end and byte sequencer
// depends on ax25fcs_pkg
`default_nettype none

module ax25fcs_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ax25fcs_pkg::job_t  push_job,
  output logic                    full,
  input  wire logic               pop,
  output logic                    avail,
  output ax25fcs_pkg::job_t       head_job
);
  import ax25fcs_pkg::*;

  job_t                mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign avail    = (count != '0);
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ax25fcs_back.sv =====
// byte sequencer: emits job bytes, folds the crc, appends check bytes, output register
// depends on ax25fcs_pkg
`default_nettype none

module ax25fcs_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_avail,
  input  wire ax25fcs_pkg::job_t  head_job,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    last_of_run,
  output logic                    frame_done,
  output logic                    seq_error
);
  import ax25fcs_pkg::*;

  logic        cur_valid;
  job_t        cur;
  logic [2:0]  idx;
  logic [15:0] crc;

  logic        out_adv;
  logic        emit;
  logic [2:0]  total;
  logic        last;
  logic        load;
  logic        is_data;
  logic        is_fcs_hi;
  logic [7:0]  sel_byte;

  assign out_adv   = !out_valid || !out_stall;
  assign emit      = cur_valid && out_adv;
  assign total     = {1'b0, cur.nbytes} + (cur.fcs_end ? 3'd2 : 3'd0);
  assign last      = (idx == total - 3'd1);
  assign load      = !cur_valid || (emit && last);
  assign q_pop     = load && q_avail;
  assign is_data   = (idx < {1'b0, cur.nbytes});
  assign is_fcs_hi = (idx == {1'b0, cur.nbytes} + 3'd1);

  always_comb begin
    if (is_data) begin
      sel_byte = cur.bytes[idx[1:0]];
    end else if (is_fcs_hi) begin
      sel_byte = ~crc[15:8];
    end else begin
      sel_byte = ~crc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= q_avail;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + 3'd1;
      end
      if (emit) begin
        if (is_data) begin
          crc <= crc_fold(crc, sel_byte);
        end else if (is_fcs_hi) begin
          crc <= CRC_INIT;
        end
      end
      if (out_adv) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head_job;
    end
    if (emit) begin
      out_byte    <= sel_byte;
      last_of_run <= last;
      frame_done  <= last && cur.fcs_end;
      seq_error   <= cur.err;
    end
  end

endmodule

`default_nettype wire
